[rtl/ffba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    // Fixed field widths
    localparam int OPC_W   = 2;
    localparam int SIZE_W  = 25;
    localparam int BIDX_W  = 12;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 13;
    localparam int PCT_W   = 7;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 32;

    localparam int PCT_SCALE = 100;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_GC    = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOFREE  = 3'd1,
        ST_NORUN   = 3'd2,
        ST_BADFREE = 3'd3,
        ST_ZERO    = 3'd4
    } status_t;

    localparam logic [CFGI_W-1:0] CFG_LIFETIME  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_PENABLE   = 2'd2;

    localparam logic [TIME_W-1:0] LIFETIME_RST  = 32'd60000000;
    localparam logic [PCT_W-1:0]  THRESHOLD_RST = 7'd80;

endpackage

`default_nettype wire

[rtl/first_fit_block_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// in       | in_valid/in_ready, opcode, size_bytes,         | to block
//          | start_block, now_time                          |
// out      | out_valid/out_ready, status, block_index,      | from block
//          | blocks_changed, free_count, used_pct,          |
//          | pressure, peak_used_blocks                     |
// cfg      | cfg_we, cfg_index, cfg_wdata (no wait)         | to block
//
// Sequence: one transaction at a time, all table work through the block table
//   (one read and one write port), one entry per cycle. Allocate: round the
//   size up to blocks (reciprocal multiply), scan up to BLOCK_COUNT entries,
//   then write each block of the run. Free: check the run head, then release
//   its blocks. Gc: every block. Every op ends with usage percent and output load.
// Reset: after rst_n the table is cleared, one entry at a time, in_ready low.
// Stalls: a finished result sits in the output register; the next input
//   transaction is taken meanwhile and only waits at its own result.

module first_fit_block_allocator #(
    parameter int BLOCK_COUNT = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ffba_pkg::OPC_W-1:0]    opcode,
    input  logic [ffba_pkg::SIZE_W-1:0]   size_bytes,
    input  logic [ffba_pkg::BIDX_W-1:0]   start_block,
    input  logic [ffba_pkg::TIME_W-1:0]   now_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffba_pkg::STAT_W-1:0]   status,
    output logic [ffba_pkg::BIDX_W-1:0]   block_index,
    output logic [ffba_pkg::CNT_W-1:0]    blocks_changed,
    output logic [ffba_pkg::CNT_W-1:0]    free_count,
    output logic [ffba_pkg::PCT_W-1:0]    used_pct,
    output logic                          pressure,
    output logic [ffba_pkg::CNT_W-1:0]    peak_used_blocks,
    input  logic                          cfg_we,
    input  logic [ffba_pkg::CFGI_W-1:0]   cfg_index,
    input  logic [ffba_pkg::CFGD_W-1:0]   cfg_wdata
);
    import ffba_pkg::*;

    localparam int AW    = $clog2(BLOCK_COUNT);
    localparam int CW    = $clog2(BLOCK_COUNT + 1);
    localparam int BBW   = $clog2(BLOCK_BYTES + 1);
    localparam int SUMW  = ((SIZE_W > BBW) ? SIZE_W : BBW) + 1;
    localparam int EW    = 1 + TIME_W + CW;   // table entry: used, stamp, run length
    localparam int AW1   = AW + 1;
    localparam int AW2   = AW + 2;

    // x / D = (x * RCP) >> K for every x below 2^N, RCP = 2^K / D + 1,
    // K = N + clog2(D)
    localparam int BB_L  = $clog2(BLOCK_BYTES);
    localparam int BB_K  = SUMW + BB_L;
    localparam int BB_RW = SUMW + 2;
    localparam int NPW   = SUMW + BB_RW;
    localparam logic [63:0] BB_RCP_V = ((64'd1 << BB_K) / 64'(BLOCK_BYTES)) + 64'd1;
    localparam logic [BB_RW-1:0] BB_RCP = BB_RW'(BB_RCP_V);

    localparam int PNW   = $clog2(BLOCK_COUNT * PCT_SCALE + 1);
    localparam int NB_L  = $clog2(BLOCK_COUNT);
    localparam int NB_K  = PNW + NB_L;
    localparam int NB_RW = PNW + 2;
    localparam int PPW   = PNW + NB_RW;
    localparam logic [63:0] NB_RCP_V = ((64'd1 << NB_K) / 64'(BLOCK_COUNT)) + 64'd1;
    localparam logic [NB_RW-1:0] NB_RCP = NB_RW'(NB_RCP_V);

    localparam logic [CW-1:0]   NB_C     = CW'(BLOCK_COUNT);
    localparam logic [AW1-1:0]  NB_A     = AW1'(BLOCK_COUNT);
    localparam logic [AW-1:0]   LAST_A   = AW'(BLOCK_COUNT - 1);
    localparam logic [SUMW-1:0] BB_M1    = SUMW'(BLOCK_BYTES - 1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_DIV   = 12'b000000000100,
        S_NEED  = 12'b000000001000,
        S_SCAN  = 12'b000000010000,
        S_AWR   = 12'b000000100000,
        S_FCHK  = 12'b000001000000,
        S_FRUN  = 12'b000010000000,
        S_GC    = 12'b000100000000,
        S_PSET  = 12'b001000000000,
        S_PCT   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t state_reg;

    // config
    logic [TIME_W-1:0] lifetime_reg;
    logic [PCT_W-1:0]  threshold_reg;
    logic              penable_reg;

    // block table
    logic [EW-1:0] mem [BLOCK_COUNT];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;

    logic              rd_used;
    logic [TIME_W-1:0] rd_stamp;
    logic [CW-1:0]     rd_rlen;

    // sequencer
    logic [AW1-1:0]    iss_reg, end_reg;
    logic              pv_reg;
    logic [AW-1:0]     p_addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic [AW-1:0]     start_reg;
    logic              is_gc_reg;
    logic [CW-1:0]     need_reg, run_reg, cnt_reg;
    logic [AW-1:0]     first_reg;
    logic [CW-1:0]     free_total_reg, peak_reg;

    // result
    status_t           res_status_reg;
    logic [AW-1:0]     res_idx_reg;
    logic [CW-1:0]     res_changed_reg;
    logic [PCT_W-1:0]  res_pct_reg;

    // output register
    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [BIDX_W-1:0]  out_idx_reg;
    logic [CNT_W-1:0]   out_changed_reg, out_free_reg, out_peak_reg;
    logic [PCT_W-1:0]   out_pct_reg;
    logic               out_press_reg;

    // constant dividers: block rounding and usage percent
    logic [SUMW-1:0] div_num_reg, need_q_reg;
    logic [NPW-1:0]  need_prod;
    logic [PNW-1:0]  pct_num_reg;
    logic [PPW-1:0]  pct_prod;

    logic            in_fire, start_ok, expired, release_blk;
    logic [CW-1:0]   run_inc;
    logic            found;
    logic [AW2-1:0]  run_end;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign start_ok = (32'(start_block) < BLOCK_COUNT);

    assign rd_used  = rd_data_reg[EW-1];
    assign rd_stamp = rd_data_reg[EW-2 -: TIME_W];
    assign rd_rlen  = rd_data_reg[CW-1:0];

    assign expired  = (now_reg - rd_stamp) > lifetime_reg;
    assign release_blk = pv_reg && rd_used &&
                         ((state_reg == S_FRUN) || ((state_reg == S_GC) && expired));

    assign run_inc = run_reg + CW'(1);
    assign found   = pv_reg && !rd_used && (run_inc == need_reg);
    assign run_end = AW2'(start_reg) + AW2'(rd_rlen);

    assign need_prod = NPW'(div_num_reg) * NPW'(BB_RCP);
    assign pct_prod  = PPW'(pct_num_reg) * PPW'(NB_RCP);

    // table port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = iss_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = p_addr_reg;
        wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = iss_reg[AW-1:0];
            end
            S_IDLE:
            begin
                rd_addr = AW'(start_block);
                rd_en   = in_fire && (opcode_t'(opcode) == OP_FREE) && start_ok;
            end
            S_SCAN, S_FRUN, S_GC:
            begin
                rd_en = (iss_reg < end_reg);
                wr_en = release_blk;
            end
            S_AWR:
            begin
                wr_en   = 1'b1;
                wr_addr = iss_reg[AW-1:0];
                wr_data = {1'b1, now_reg, (cnt_reg == '0) ? need_reg : CW'(0)};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg  <= LIFETIME_RST;
            threshold_reg <= THRESHOLD_RST;
            penable_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIFETIME:  lifetime_reg  <= cfg_wdata[TIME_W-1:0];
                CFG_THRESHOLD: threshold_reg <= cfg_wdata[PCT_W-1:0];
                CFG_PENABLE:   penable_reg   <= cfg_wdata[0];
                default:       lifetime_reg  <= lifetime_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            iss_reg        <= '0;
            end_reg        <= '0;
            pv_reg         <= 1'b0;
            free_total_reg <= NB_C;
            peak_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pv_reg     <= rd_en;
            p_addr_reg <= rd_addr;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    iss_reg <= iss_reg + AW1'(1);
                    if (iss_reg[AW-1:0] == LAST_A)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        now_reg         <= now_time;
                        start_reg       <= AW'(start_block);
                        is_gc_reg       <= (opcode_t'(opcode) == OP_GC);
                        res_status_reg  <= ST_OK;
                        res_idx_reg     <= '0;
                        res_changed_reg <= '0;
                        unique case (opcode_t'(opcode))
                            OP_ALLOC:
                            begin
                                if (size_bytes == '0)
                                begin
                                    res_status_reg <= ST_ZERO;
                                    state_reg      <= S_PSET;
                                end
                                else
                                begin
                                    // ceil(size / BLOCK_BYTES)
                                    div_num_reg <= SUMW'(size_bytes) + BB_M1;
                                    state_reg   <= S_DIV;
                                end
                            end
                            OP_FREE:
                            begin
                                if (!start_ok)
                                begin
                                    res_status_reg <= ST_BADFREE;
                                    state_reg      <= S_PSET;
                                end
                                else
                                begin
                                    state_reg <= S_FCHK;
                                end
                            end
                            OP_GC:
                            begin
                                iss_reg   <= '0;
                                end_reg   <= NB_A;
                                state_reg <= S_GC;
                            end
                            default:
                            begin
                                state_reg <= S_PSET;
                            end
                        endcase
                    end
                end

                S_DIV:
                begin
                    need_q_reg <= SUMW'(need_prod >> BB_K);
                    state_reg  <= S_NEED;
                end

                S_NEED:
                begin
                    if (need_q_reg > SUMW'(free_total_reg))
                    begin
                        res_status_reg <= ST_NOFREE;
                        state_reg      <= S_PSET;
                    end
                    else
                    begin
                        need_reg  <= need_q_reg[CW-1:0];
                        run_reg   <= '0;
                        iss_reg   <= '0;
                        end_reg   <= NB_A;
                        state_reg <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (rd_en)
                    begin
                        iss_reg <= iss_reg + AW1'(1);
                    end
                    if (pv_reg)
                    begin
                        if (rd_used)
                        begin
                            run_reg <= '0;
                        end
                        else
                        begin
                            run_reg <= run_inc;
                            if (run_reg == '0)
                            begin
                                first_reg <= p_addr_reg;
                            end
                        end
                        if (found)
                        begin
                            // write pointer starts at the run's first block
                            iss_reg   <= AW1'((run_reg == '0) ? p_addr_reg : first_reg);
                            first_reg <= (run_reg == '0) ? p_addr_reg : first_reg;
                            cnt_reg   <= '0;
                            state_reg <= S_AWR;
                        end
                        else if (p_addr_reg == LAST_A)
                        begin
                            res_status_reg <= ST_NORUN;
                            state_reg      <= S_PSET;
                        end
                    end
                end

                S_AWR:
                begin
                    iss_reg <= iss_reg + AW1'(1);
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == need_reg - CW'(1))
                    begin
                        free_total_reg  <= free_total_reg - need_reg;
                        if (NB_C - free_total_reg + need_reg > peak_reg)
                        begin
                            peak_reg <= NB_C - free_total_reg + need_reg;
                        end
                        res_idx_reg     <= first_reg;
                        res_changed_reg <= need_reg;
                        state_reg       <= S_PSET;
                    end
                end

                S_FCHK:
                begin
                    if (!rd_used || (rd_rlen == '0))
                    begin
                        res_status_reg <= ST_BADFREE;
                        state_reg      <= S_PSET;
                    end
                    else
                    begin
                        iss_reg   <= AW1'(start_reg);
                        end_reg   <= (run_end > AW2'(BLOCK_COUNT)) ? NB_A : run_end[AW1-1:0];
                        state_reg <= S_FRUN;
                    end
                end

                S_FRUN, S_GC:
                begin
                    if (rd_en)
                    begin
                        iss_reg <= iss_reg + AW1'(1);
                    end
                    if (release_blk)
                    begin
                        free_total_reg  <= free_total_reg + CW'(1);
                        res_changed_reg <= res_changed_reg + CW'(1);
                    end
                    if (!rd_en && !pv_reg)
                    begin
                        state_reg <= S_PSET;
                    end
                end

                S_PSET:
                begin
                    // usage percent = (used * 100) / BLOCK_COUNT
                    pct_num_reg <= PNW'(NB_C - free_total_reg) * PNW'(PCT_SCALE);
                    state_reg   <= S_PCT;
                end

                S_PCT:
                begin
                    res_pct_reg <= PCT_W'(pct_prod >> NB_K);
                    state_reg   <= S_DONE;
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_status_reg  <= res_status_reg;
                        out_idx_reg     <= BIDX_W'(res_idx_reg);
                        out_changed_reg <= CNT_W'(res_changed_reg);
                        out_free_reg    <= CNT_W'(free_total_reg);
                        out_peak_reg    <= CNT_W'(peak_reg);
                        out_pct_reg     <= res_pct_reg;
                        out_press_reg   <= is_gc_reg && penable_reg &&
                                           (res_pct_reg > threshold_reg);
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign block_index      = out_idx_reg;
    assign blocks_changed   = out_changed_reg;
    assign free_count       = out_free_reg;
    assign used_pct         = out_pct_reg;
    assign pressure         = out_press_reg;
    assign peak_used_blocks = out_peak_reg;

endmodule

`default_nettype wire

[dv/ffba_checker.sv]
`timescale 1ns / 1ps

module ffba_checker #(
    parameter int BLOCK_COUNT = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [ffba_pkg::OPC_W-1:0]  opcode,
    input  logic [ffba_pkg::SIZE_W-1:0] size_bytes,
    input  logic [ffba_pkg::BIDX_W-1:0] start_block,
    input  logic [ffba_pkg::TIME_W-1:0] now_time,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [ffba_pkg::STAT_W-1:0] status,
    input  logic [ffba_pkg::BIDX_W-1:0] block_index,
    input  logic [ffba_pkg::CNT_W-1:0]  blocks_changed,
    input  logic [ffba_pkg::CNT_W-1:0]  free_count,
    input  logic [ffba_pkg::PCT_W-1:0]  used_pct,
    input  logic                        pressure,
    input  logic [ffba_pkg::CNT_W-1:0]  peak_used_blocks,
    input  logic                        cfg_we,
    input  logic [ffba_pkg::CFGI_W-1:0] cfg_index,
    input  logic [ffba_pkg::CFGD_W-1:0] cfg_wdata,
    output int                          fail_count,
    output int                          pending_count
);
    import ffba_pkg::*;

    typedef struct packed {
        status_t           st;
        logic [BIDX_W-1:0] idx;
        logic [CNT_W-1:0]  changed;
        logic [CNT_W-1:0]  free_n;
        logic [PCT_W-1:0]  pct;
        logic              press;
        logic [CNT_W-1:0]  peak;
    } alloc_result_t;

    // shadow of the block table and counters
    logic              blk_used  [BLOCK_COUNT];
    logic [TIME_W-1:0] blk_stamp [BLOCK_COUNT];
    int unsigned       blk_run   [BLOCK_COUNT];
    int unsigned       free_cnt;
    int unsigned       peak_cnt;

    logic [TIME_W-1:0] lifetime;
    logic [PCT_W-1:0]  threshold;
    logic              press_en;

    alloc_result_t expected_q[$];

    function automatic int unsigned usage_pct();
        return ((BLOCK_COUNT - free_cnt) * PCT_SCALE) / BLOCK_COUNT;
    endfunction

    function automatic void release_blk(int unsigned i);
        blk_used[i]  = 1'b0;
        blk_stamp[i] = '0;
        blk_run[i]   = 0;
        free_cnt++;
    endfunction

    function automatic alloc_result_t predict_op(logic [OPC_W-1:0] op,
                                                 logic [SIZE_W-1:0] sz,
                                                 logic [BIDX_W-1:0] start,
                                                 logic [TIME_W-1:0] now);
        alloc_result_t r;
        longint unsigned need;
        int unsigned     run;
        int unsigned     first;
        int unsigned     n;
        r = '0;
        r.st = ST_OK;
        run = 0;
        first = 0;
        n = 0;
        case (op)
            OP_ALLOC:
            begin
                need = (longint'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                if (sz == 0)
                    r.st = ST_ZERO;
                else if (need > free_cnt)
                    r.st = ST_NOFREE;
                else
                begin
                    for (int i = 0; i < BLOCK_COUNT; i++)
                    begin
                        if (!blk_used[i])
                        begin
                            if (run == 0)
                                first = i;
                            run++;
                            if (run == need)
                                break;
                        end
                        else
                            run = 0;
                    end
                    if (run < need)
                        r.st = ST_NORUN;
                    else
                    begin
                        for (int i = 0; i < need; i++)
                        begin
                            blk_used[first+i]  = 1'b1;
                            blk_stamp[first+i] = now;
                            blk_run[first+i]   = 0;
                        end
                        blk_run[first] = 32'(need);
                        free_cnt -= 32'(need);
                        if (BLOCK_COUNT - free_cnt > peak_cnt)
                            peak_cnt = BLOCK_COUNT - free_cnt;
                        r.idx = BIDX_W'(first);
                        n = 32'(need);
                    end
                end
            end
            OP_FREE:
            begin
                if (start >= BLOCK_COUNT || !blk_used[start] || blk_run[start] == 0)
                    r.st = ST_BADFREE;
                else
                begin
                    run = blk_run[start];
                    for (int i = 0; i < run && start + i < BLOCK_COUNT; i++)
                        if (blk_used[start+i])
                        begin
                            release_blk(start + i);
                            n++;
                        end
                    blk_run[start] = 0;
                end
            end
            OP_GC:
            begin
                for (int i = 0; i < BLOCK_COUNT; i++)
                    if (blk_used[i] && TIME_W'(now - blk_stamp[i]) > lifetime)
                    begin
                        release_blk(i);
                        n++;
                    end
                r.press = (usage_pct() > threshold) && press_en;
            end
            default: ;
        endcase
        r.changed = CNT_W'(n);
        r.free_n  = CNT_W'(free_cnt);
        r.pct     = PCT_W'(usage_pct());
        r.peak    = CNT_W'(peak_cnt);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < BLOCK_COUNT; i++)
            begin
                blk_used[i]  = 1'b0;
                blk_stamp[i] = '0;
                blk_run[i]   = 0;
            end
            free_cnt   = BLOCK_COUNT;
            peak_cnt   = 0;
            lifetime   = LIFETIME_RST;
            threshold  = THRESHOLD_RST;
            press_en   = 1'b0;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_LIFETIME:  lifetime  = cfg_wdata;
                    CFG_THRESHOLD: threshold = cfg_wdata[PCT_W-1:0];
                    CFG_PENABLE:   press_en  = cfg_wdata[0];
                    default: ;
                endcase
            // result side first: a result never belongs to a same-edge input
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transaction, status %0d", status);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (status !== exp_r.st)
                    begin
                        $error("status exp %0d got %0d", exp_r.st, status);
                        fail_count++;
                    end
                    if (block_index !== exp_r.idx)
                    begin
                        $error("block_index exp %0d got %0d", exp_r.idx, block_index);
                        fail_count++;
                    end
                    if (blocks_changed !== exp_r.changed)
                    begin
                        $error("blocks_changed exp %0d got %0d", exp_r.changed,
                               blocks_changed);
                        fail_count++;
                    end
                    if (free_count !== exp_r.free_n)
                    begin
                        $error("free_count exp %0d got %0d", exp_r.free_n, free_count);
                        fail_count++;
                    end
                    if (used_pct !== exp_r.pct)
                    begin
                        $error("used_pct exp %0d got %0d", exp_r.pct, used_pct);
                        fail_count++;
                    end
                    if (pressure !== exp_r.press)
                    begin
                        $error("pressure exp %0d got %0d", exp_r.press, pressure);
                        fail_count++;
                    end
                    if (peak_used_blocks !== exp_r.peak)
                    begin
                        $error("peak_used_blocks exp %0d got %0d", exp_r.peak,
                               peak_used_blocks);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_op(opcode, size_bytes, start_block, now_time));
        end
        pending_count = expected_q.size();
    end

endmodule

[dv/tb_first_fit_block_allocator.sv]
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int NBLK       = 4096;
    localparam int BBYTES     = 4096;
    localparam int IDLE_LIMIT = 40000;   // ~4x worst item incl. long receiver hold
    localparam int LONG_HOLD  = 3000;
    localparam int RAND_ITEMS = 30;      // per config phase

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OPC_W-1:0]  opcode = '0;
    logic [SIZE_W-1:0] size_bytes = '0;
    logic [BIDX_W-1:0] start_block = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [STAT_W-1:0] status;
    logic [BIDX_W-1:0] block_index;
    logic [CNT_W-1:0]  blocks_changed;
    logic [CNT_W-1:0]  free_count;
    logic [PCT_W-1:0]  used_pct;
    logic              pressure;
    logic [CNT_W-1:0]  peak_used_blocks;
    logic              cfg_we = 1'b0;
    logic [CFGI_W-1:0] cfg_index = '0;
    logic [CFGD_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending_count;
    int sent_cnt = 0;
    int done_cnt = 0;
    int idle_cycles = 0;
    bit long_hold_req = 1'b0;
    logic [TIME_W-1:0] clock_us = 32'd100;   // advancing time stamp for traffic

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    first_fit_block_allocator #(.BLOCK_COUNT(NBLK), .BLOCK_BYTES(BBYTES)) i_dut (.*);

    ffba_checker #(.BLOCK_COUNT(NBLK), .BLOCK_BYTES(BBYTES)) i_checker (.*);

    // transaction counters and a watchdog on handshake activity
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sent_cnt <= sent_cnt + 1;
        if (out_valid && out_ready)
            done_cnt <= done_cnt + 1;
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall per transaction, a zero-stall burst every 40,
    // and one long hold-off on request so the block backs up its input.
    initial
    begin
        int gap;
        int n;
        n = 0;
        @(negedge clk);
        forever
        begin
            gap = (n % 40 < 8) ? 0 : $urandom_range(0, 19);
            if (long_hold_req)
            begin
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
            n++;
        end
    end

    // One input transaction. Entered and left at a falling edge.
    task automatic send_op(opcode_t op, logic [SIZE_W-1:0] sz,
                           logic [BIDX_W-1:0] start, logic [TIME_W-1:0] t);
        int gap;
        gap = (sent_cnt % 40 < 6) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode      = op;
        size_bytes  = sz;
        start_block = start;
        now_time    = t;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pause: hold valid low until every result is back.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (done_cnt != sent_cnt || pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_op();
        int pick;
        logic [SIZE_W-1:0] sz;
        logic [BIDX_W-1:0] start;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0)
            clock_us = $urandom;     // exercise every time bit, incl. wrap
        else
            clock_us = clock_us + $urandom_range(0, 400);
        // sizes: mostly a few blocks, sometimes huge, rarely zero
        case ($urandom_range(0, 19))
            0:       sz = '0;
            1, 2, 3: sz = $urandom_range(1, 16777216);
            default: sz = $urandom_range(1, 40000);
        endcase
        // first-fit keeps live runs low, so most frees aim there
        start = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NBLK-1)
                                            : $urandom_range(0, 127);
        if (pick < 45)
            send_op(OP_ALLOC, sz, start, clock_us);
        else if (pick < 78)
            send_op(OP_FREE, sz, start, clock_us);
        else if (pick < 95)
            send_op(OP_GC, sz, start, clock_us);
        else
            send_op(OP_NOP, sz, start, clock_us);
    endtask

    initial
    begin
        logic [TIME_W-1:0] lt_set [4];
        logic [CFGD_W-1:0] th_set [4];
        logic              en_set [4];
        lt_set = '{32'd2000, 32'hFFFF_FFFF, 32'd0, $urandom};
        th_set = '{32'd5, 32'd127, 32'd0, 32'd100};
        en_set = '{1'b1, 1'b1, 1'b1, 1'b0};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config, boundary sizes and every status
        send_op(OP_ALLOC, 25'd0, 12'd0, 32'd100);            // zero size
        send_op(OP_ALLOC, 25'd1, 12'hFFF, 32'd100);          // one byte -> one block
        send_op(OP_FREE,  25'h1FF_FFFF, 12'd0, 32'd100);
        send_op(OP_ALLOC, 25'd16777216, 12'd0, 32'd100);     // whole pool
        send_op(OP_ALLOC, 25'd1, 12'd0, 32'd100);            // too few free
        send_op(OP_GC,    25'd0, 12'd0, 32'd100);            // nothing aged
        send_op(OP_FREE,  25'd0, 12'd1, 32'd100);            // not a run start
        send_op(OP_FREE,  25'd0, 12'd0, 32'd100);            // frees all
        send_op(OP_FREE,  25'd0, 12'hFFF, 32'd100);          // block already free
        send_op(OP_NOP,   25'h1FF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
        // fragment: four runs of 8, free two, then ask for more than any hole
        repeat (4) send_op(OP_ALLOC, 25'd32768, 12'd0, 32'd200);
        send_op(OP_FREE,  25'd0, 12'd8, 32'd200);
        send_op(OP_FREE,  25'd0, 12'd24, 32'd200);
        send_op(OP_ALLOC, 25'd16683008, 12'd0, 32'd200);     // no run long enough
        send_op(OP_ALLOC, 25'd4097, 12'd0, 32'd300);         // rounds up to 2
        send_op(OP_FREE,  25'd0, 12'd8, 32'd300);
        send_op(OP_GC,    25'd0, 12'd0, 32'hFFFF_FFFF);      // everything aged out

        // random phases, each under its own register setting
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            write_cfg(CFG_LIFETIME, lt_set[p]);
            write_cfg(CFG_THRESHOLD, th_set[p]);
            write_cfg(CFG_PENABLE, {31'd0, en_set[p]});
            if (p == 1)
                long_hold_req = 1'b1;
            for (int k = 0; k < RAND_ITEMS; k++)
                random_op();
        end

        wait_drained();
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator.sv
dv/ffba_checker.sv
dv/tb_first_fit_block_allocator.sv
